// File: sv/counter_priority_task_scheduler_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the counter/priority task scheduler
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_CORE_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CPTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define CPTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CPTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CPTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: sv/cpts_pkg.sv
// ---------------------------------------------------------------------------
// Scheduler package
// Types, codes and constants shared by the scheduler modules.
// ---------------------------------------------------------------------------
package cpts_pkg;

   localparam int unsigned TASK_SLOTS_DEFAULT = 64;
   localparam int unsigned TASK_W  = 6;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned PRIO_W  = 8;
   localparam int unsigned NOPRE_W = 8;
   localparam int unsigned FUNC_W  = 3;

   localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_YIELD = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PDIS  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_PEN   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd4;

   typedef logic signed [COUNT_W-1:0] count_type;

   localparam count_type COUNT_MIN  = 16'sh8000;
   localparam count_type COUNT_NONE = -16'sd1;
   localparam logic [NOPRE_W-1:0] NOPRE_MAX = 8'hFF;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [TASK_W-1:0]  slot;
      logic               present;
      logic               ready_req;
      logic [PRIO_W-1:0]  prio;
      logic [7:0]         start_count;
   } req_payload_type;

   typedef struct packed {
      logic [TASK_W-1:0]  current_task;
      logic               switched;
      logic               rescheduled;
      count_type          current_count;
   } rsp_payload_type;

   // One slot of the task table as held in memory.
   typedef struct packed {
      logic               present;
      logic               ready;
      count_type          count;
      logic [PRIO_W-1:0]  prio;
      logic [NOPRE_W-1:0] nopre;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctrl_type;

   typedef struct packed {
      count_type best;
      count_type zero_count;
   } scan_result_type;

   // Slot 0 comes out of reset holding the idle task.
   function automatic entry_type reset_entry(input logic is_slot0);
      entry_type e;
      e.present = is_slot0;
      e.ready   = is_slot0;
      e.count   = '0;
      e.prio    = is_slot0 ? PRIO_W'(1) : '0;
      e.nopre   = '0;
      return e;
   endfunction

endpackage

// File: sv/cpts_stream_if.sv
// ---------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload item per handshake.
// ---------------------------------------------------------------------------
interface cpts_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/cpts_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module cpts_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/cpts_scan.sv
// ---------------------------------------------------------------------------
// Selection scan unit
// Tracks the best ready slot over a stream of table reads.
// ---------------------------------------------------------------------------
module cpts_scan #(
   parameter int unsigned TASK_SLOTS = cpts_pkg::TASK_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  cpts_pkg::scan_ctrl_type       ctrl,
   input  logic [$clog2(TASK_SLOTS)-1:0] idx,
   input  cpts_pkg::entry_type           entry,
   output cpts_pkg::scan_result_type     result,
   output logic [$clog2(TASK_SLOTS)-1:0] win
);
   import cpts_pkg::*;

   localparam int unsigned IDX_W = $clog2(TASK_SLOTS);

   count_type          best_ff,  best_in;
   count_type          zero_ff,  zero_in;
   logic [IDX_W-1:0]   win_ff,   win_in;

   always_comb begin
      best_in = best_ff;
      zero_in = zero_ff;
      win_in  = win_ff;
      priority if (ctrl.clear) begin
         best_in = COUNT_NONE;
         win_in  = '0;
      end else if (ctrl.sample) begin
         if (idx == '0) begin
            zero_in = entry.count;
         end
         // Strictly greater keeps the lowest index on a tie.
         if (entry.present && entry.ready && (entry.count > best_ff)) begin
            best_in = entry.count;
            win_in  = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      zero_ff <= zero_in;
      win_ff  <= win_in;
   end

   assign result.best       = best_ff;
   assign result.zero_count = zero_ff;
   assign win               = win_ff;
endmodule

// File: sv/counter_priority_task_scheduler_core.sv
// ---------------------------------------------------------------------------
// Counter/priority task scheduler core
// Task table in one RAM, walked by a sequencer for selection and refill.
// ---------------------------------------------------------------------------
// After reset the block writes the initial task table into its RAM and
// takes no item meanwhile. An item that does not reschedule goes through a
// read of the running task's slot, the update and write-back, and the load
// of the output register. A reschedule adds a selection pass; when the best
// counter is zero, a refill pass and another selection pass follow. Every
// pass is bound by the single read port of the table RAM, which delivers one
// slot per cycle. A new item is taken while the previous result still waits
// in the output register.
`include "counter_priority_task_scheduler_core_macros.svh"

module counter_priority_task_scheduler_core #(
   parameter int unsigned TASK_SLOTS = cpts_pkg::TASK_SLOTS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   cpts_stream_if.sink   req_chan,
   cpts_stream_if.source rsp_chan
);
   import cpts_pkg::*;

   localparam int unsigned IDX_W = $clog2(TASK_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

   typedef enum logic [9:0] {
      ST_CLEAR       = 10'b00_0000_0001,
      ST_IDLE        = 10'b00_0000_0010,
      ST_MODIFY      = 10'b00_0000_0100,
      ST_SCAN        = 10'b00_0000_1000,
      ST_SCAN_WAIT   = 10'b00_0001_0000,
      ST_DECIDE      = 10'b00_0010_0000,
      ST_REFILL      = 10'b00_0100_0000,
      ST_REFILL_WAIT = 10'b00_1000_0000,
      ST_DONE        = 10'b01_0000_0000,
      ST_SPARE       = 10'b10_0000_0000
   } state_type;

   state_type         state_ff,     state_in;
   logic [IDX_W-1:0]  addr_ff,      addr_in;
   logic              pending_ff,   pending_in;
   logic [IDX_W-1:0]  pend_idx_ff;
   req_payload_type   req_ff,       req_in;
   logic [IDX_W-1:0]  run_ff,       run_in;
   logic [IDX_W-1:0]  prev_ff,      prev_in;
   logic              sched_ff,     sched_in;
   count_type         res_count_ff, res_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff,  rsp_data_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type         cur;
   entry_type         upd;
   count_type         tick_count;
   logic              slot_ok;
   scan_ctrl_type     scan_ctrl;
   scan_result_type   scan_res;
   logic [IDX_W-1:0]  scan_win;

   cpts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TASK_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign cur = entry_type'(rd_raw);

   cpts_scan #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_scan (
      .clock  (clock),
      .ctrl   (scan_ctrl),
      .idx    (pend_idx_ff),
      .entry  (cur),
      .result (scan_res),
      .win    (scan_win)
   );

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign slot_ok    = (32'(req_ff.slot) < TASK_SLOTS);
   assign tick_count = (cur.count == COUNT_MIN) ? cur.count : cur.count - 16'sd1;
   assign pending_in = (state_ff == ST_SCAN) || (state_ff == ST_REFILL);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      req_in       = req_ff;
      run_in       = run_ff;
      prev_in      = prev_ff;
      sched_in     = sched_ff;
      res_count_in = res_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = cur;
      rd_addr      = addr_ff;
      upd          = cur;
      scan_ctrl    = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = reset_entry(addr_ff == '0);
            if (addr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
               addr_in  = '0;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end

         ST_IDLE: begin
            rd_addr = run_ff;
            if (req_chan.valid) begin
               req_in   = req_chan.payload;
               prev_in  = run_ff;
               state_in = ST_MODIFY;
            end
         end

         ST_MODIFY: begin
            wr_addr      = run_ff;
            sched_in     = 1'b0;
            res_count_in = cur.count;
            unique case (req_ff.func)
               FUNC_TICK: begin
                  wr_en = 1'b1;
                  if ((tick_count > 16'sd0) || (cur.nopre != '0)) begin
                     upd.count = tick_count;
                  end else begin
                     upd.count = '0;
                     sched_in  = 1'b1;
                  end
                  wr_data      = upd;
                  res_count_in = upd.count;
               end
               FUNC_YIELD: begin
                  wr_en        = 1'b1;
                  upd.count    = '0;
                  sched_in     = 1'b1;
                  wr_data      = upd;
                  res_count_in = upd.count;
               end
               FUNC_PDIS: begin
                  wr_en = 1'b1;
                  if (cur.nopre != NOPRE_MAX) begin
                     upd.nopre = cur.nopre + NOPRE_W'(1);
                  end
                  wr_data = upd;
               end
               FUNC_PEN: begin
                  wr_en = 1'b1;
                  if (cur.nopre != '0) begin
                     upd.nopre = cur.nopre - NOPRE_W'(1);
                  end
                  wr_data = upd;
               end
               FUNC_SET: begin
                  if (slot_ok) begin
                     wr_en           = 1'b1;
                     wr_addr         = IDX_W'(req_ff.slot);
                     wr_data.present = req_ff.present;
                     wr_data.ready   = req_ff.ready_req;
                     wr_data.prio    = (req_ff.prio == '0) ? PRIO_W'(1) : req_ff.prio;
                     wr_data.count   = count_type'({8'd0, req_ff.start_count});
                     wr_data.nopre   = '0;
                     // The running task may be the one just rewritten.
                     if (IDX_W'(req_ff.slot) == run_ff) begin
                        res_count_in = wr_data.count;
                     end
                  end
               end
               default: begin
               end
            endcase
            addr_in  = '0;
            state_in = sched_in ? ST_SCAN : ST_DONE;
         end

         ST_SCAN: begin
            scan_ctrl.clear  = (addr_ff == '0);
            scan_ctrl.sample = pending_ff;
            if (addr_ff == LAST_IDX) begin
               state_in = ST_SCAN_WAIT;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end

         ST_SCAN_WAIT: begin
            scan_ctrl.sample = pending_ff;
            state_in         = ST_DECIDE;
         end

         ST_DECIDE: begin
            if (scan_res.best == '0) begin
               addr_in  = '0;
               state_in = ST_REFILL;
            end else begin
               // With no candidate the winner is still slot 0.
               run_in       = scan_win;
               res_count_in = (scan_res.best == COUNT_NONE) ? scan_res.zero_count
                                                            : scan_res.best;
               state_in     = ST_DONE;
            end
         end

         ST_REFILL, ST_REFILL_WAIT: begin
            // Read slot n while slot n-1 is written back; the wait state only writes the last slot.
            wr_en         = pending_ff && cur.present;
            wr_addr       = pend_idx_ff;
            upd.count     = (cur.count >>> 1) + count_type'({8'd0, cur.prio});
            wr_data       = upd;
            if (state_ff == ST_REFILL_WAIT) begin
               addr_in  = '0;
               state_in = ST_SCAN;
            end else if (addr_ff == LAST_IDX) begin
               state_in = ST_REFILL_WAIT;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.current_task  = TASK_W'(run_ff);
               rsp_data_in.switched      = (run_ff != prev_ff);
               rsp_data_in.rescheduled   = sched_ff;
               rsp_data_in.current_count = res_count_ff;
               state_in                  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         pending_ff   <= 1'b0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         pending_ff   <= pending_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff  <= addr_ff;
      req_ff       <= req_in;
      prev_ff      <= prev_in;
      sched_ff     <= sched_in;
      res_count_ff <= res_count_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `CPTS_ASSERT_NEXT(a_accept_to_modify, clock, reset,
      req_chan.valid && req_chan.ready, state_ff == ST_MODIFY,
      "accepted item did not reach the update step")
   `CPTS_ASSERT_IMPL(a_switch_needs_sched, clock, reset,
      rsp_chan.valid && rsp_chan.payload.switched, rsp_chan.payload.rescheduled,
      "task switch reported without a selection pass")
   `CPTS_ASSERT_NEXT(a_decide_to_done, clock, reset,
      (state_ff == ST_DECIDE) && (scan_res.best != '0), state_ff == ST_DONE,
      "non-zero best counter did not finish the reschedule")

endmodule

// File: tb/sv/tb_counter_priority_task_scheduler_core.sv
// ---------------------------------------------------------------------------
// Testbench for the counter/priority task scheduler core
// Drives scheduler operations through the request channel and checks every
// result against a cycle-free model of the task table kept in the bench.
// ---------------------------------------------------------------------------
module tb_counter_priority_task_scheduler_core;
   import cpts_pkg::*;

   localparam int unsigned TASK_SLOTS    = TASK_SLOTS_DEFAULT;
   localparam int unsigned CLOCK_PERIOD  = 10;
   localparam int unsigned RESET_CYCLES  = 5;
   localparam int unsigned RANDOM_ITEMS  = 1064;
   localparam int unsigned LONG_HOLD_OFF = 400;
   localparam int unsigned IDLE_LIMIT    = 5000;
   localparam int unsigned SETTLE_CYCLES = 3 * TASK_SLOTS + 16;
   localparam int          COUNT_FLOOR   = int'(COUNT_MIN);

   localparam logic [FUNC_W-1:0] FUNC_FIRST_SPARE = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_LAST_SPARE  = 3'd7;

   typedef enum {RX_STEADY, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   cpts_stream_if #(.payload_type(req_payload_type)) req_chan ();
   cpts_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   counter_priority_task_scheduler_core #(
      .TASK_SLOTS(TASK_SLOTS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Model of the task table.
   bit           task_present [TASK_SLOTS];
   bit           task_ready   [TASK_SLOTS];
   int           task_count   [TASK_SLOTS];
   byte unsigned task_prio    [TASK_SLOTS];
   byte unsigned task_nopre   [TASK_SLOTS];
   int unsigned  running_slot;

   rsp_payload_type decisions_due [$];
   rsp_payload_type decision_head;

   int          failures = 0;
   int unsigned burst_left = 0;
   bit          gaps_enabled = 1'b1;
   bit          hold_off_pending = 1'b0;
   int unsigned hold_off_left = 0;
   rx_mode_type rx_mode = RX_STEADY;
   int unsigned rx_left = 0;
   int unsigned idle_cycles = 0;

   function automatic void reset_task_table();
      for (int i = 0; i < TASK_SLOTS; i++) begin
         task_present[i] = 1'b0;
         task_ready[i]   = 1'b0;
         task_count[i]   = 0;
         task_prio[i]    = 8'd0;
         task_nopre[i]   = 8'd0;
      end
      // Slot 0 holds the idle task.
      task_present[0] = 1'b1;
      task_ready[0]   = 1'b1;
      task_prio[0]    = 8'd1;
      running_slot    = 0;
   endfunction

   // Picks the runnable slot with the largest counter, refilling all counters
   // once when the best of them has run out.
   function automatic int unsigned select_next_task();
      int          best;
      int unsigned winner;
      while (1'b1) begin
         best   = -1;
         winner = 0;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            if (task_present[i] && task_ready[i] && task_count[i] > best) begin
               best   = task_count[i];
               winner = i;
            end
         end
         if (best != 0)
            return winner;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            if (task_present[i])
               task_count[i] = (task_count[i] >>> 1) + int'(task_prio[i]);
         end
      end
      return 0;
   endfunction

   function automatic rsp_payload_type apply_scheduler_op(input req_payload_type op);
      rsp_payload_type outcome;
      int unsigned     previous;
      bit              resched;
      previous = running_slot;
      resched  = 1'b0;
      case (op.func)
         FUNC_TICK: begin
            if (task_count[running_slot] > COUNT_FLOOR)
               task_count[running_slot]--;
            if (!(task_count[running_slot] > 0 || task_nopre[running_slot] > 0)) begin
               task_count[running_slot] = 0;
               resched = 1'b1;
            end
         end
         FUNC_YIELD: begin
            task_count[running_slot] = 0;
            resched = 1'b1;
         end
         FUNC_PDIS: begin
            if (task_nopre[running_slot] < NOPRE_MAX)
               task_nopre[running_slot]++;
         end
         FUNC_PEN: begin
            if (task_nopre[running_slot] > 0)
               task_nopre[running_slot]--;
         end
         FUNC_SET: begin
            if (op.slot < TASK_SLOTS) begin
               task_present[op.slot] = op.present;
               task_ready[op.slot]   = op.ready_req;
               task_prio[op.slot]    = (op.prio == '0) ? 8'd1 : op.prio;
               task_count[op.slot]   = int'(op.start_count);
               task_nopre[op.slot]   = 8'd0;
            end
         end
         default: ;
      endcase
      if (resched)
         running_slot = select_next_task();
      outcome.current_task  = TASK_W'(running_slot);
      outcome.switched      = (running_slot != previous);
      outcome.rescheduled   = resched;
      outcome.current_count = count_type'(task_count[running_slot]);
      return outcome;
   endfunction

   function automatic req_payload_type make_op(input logic [FUNC_W-1:0] func,
                                               input int unsigned slot = 0,
                                               input bit present = 1'b0,
                                               input bit ready_req = 1'b0,
                                               input int unsigned prio = 0,
                                               input int unsigned start_count = 0);
      req_payload_type op;
      op.func        = func;
      op.slot        = TASK_W'(slot);
      op.present     = present;
      op.ready_req   = ready_req;
      op.prio        = PRIO_W'(prio);
      op.start_count = 8'(start_count);
      return op;
   endfunction

   // Mostly ticks and task writes on a handful of low slots with small
   // counters and priorities, so that refills and switches come often.
   function automatic req_payload_type draw_random_op();
      req_payload_type op;
      int unsigned     roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         op.func = FUNC_TICK;
      else if (roll < 53)
         op.func = FUNC_YIELD;
      else if (roll < 78)
         op.func = FUNC_SET;
      else if (roll < 86)
         op.func = FUNC_PDIS;
      else if (roll < 96)
         op.func = FUNC_PEN;
      else
         op.func = FUNC_W'($urandom_range(FUNC_FIRST_SPARE, FUNC_LAST_SPARE));
      op.slot      = ($urandom_range(0, 9) < 7) ? TASK_W'($urandom_range(0, 7))
                                                : TASK_W'($urandom_range(0, TASK_SLOTS - 1));
      op.present   = ($urandom_range(0, 19) < 17);
      op.ready_req = ($urandom_range(0, 9) < 8);
      roll = $urandom_range(0, 9);
      if (roll < 6)
         op.prio = PRIO_W'($urandom_range(1, 4));
      else if (roll < 7)
         op.prio = '0;
      else
         op.prio = PRIO_W'($urandom_range(0, 255));
      op.start_count = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 10))
                                                  : 8'($urandom_range(0, 255));
      return op;
   endfunction

   task automatic send_op(input req_payload_type op);
      int unsigned gap;
      if (gaps_enabled && burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 16);
      end
      req_chan.payload <= op;
      req_chan.valid   <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      decisions_due.push_back(apply_scheduler_op(op));
      if (burst_left != 0)
         burst_left--;
   endtask

   task automatic send_func(input logic [FUNC_W-1:0] func);
      send_op(make_op(func));
   endtask

   task automatic send_task_slot(input int unsigned slot, input bit present, input bit ready_req,
                                 input int unsigned prio, input int unsigned start_count);
      send_op(make_op(FUNC_SET, slot, present, ready_req, prio, start_count));
   endtask

   // Stops offering items and waits until every result has come back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (decisions_due.size() != 0);
      burst_left = 0;
   endtask

   task automatic test_idle_task();
      send_func(FUNC_TICK);
      send_func(FUNC_PEN);
      send_func(FUNC_FIRST_SPARE);
      send_func(FUNC_LAST_SPARE);
      send_func(FUNC_YIELD);
      drain_results();
   endtask

   task automatic test_task_table();
      send_task_slot(TASK_SLOTS - 1, 1'b1, 1'b1, 255, 255);
      send_task_slot(1, 1'b1, 1'b1, 0, 0);
      send_func(FUNC_YIELD);
      send_func(FUNC_TICK);
      // Rewriting the running slot leaves the running index alone.
      send_task_slot(TASK_SLOTS - 1, 1'b1, 1'b1, 2, 3);
      repeat (3) send_func(FUNC_TICK);
      send_func(FUNC_YIELD);
      // With nothing runnable the scheduler falls back to slot 0.
      send_task_slot(TASK_SLOTS - 1, 1'b0, 1'b1, 1, 9);
      send_task_slot(1, 1'b1, 1'b0, 1, 9);
      send_task_slot(0, 1'b1, 1'b0, 1, 5);
      send_func(FUNC_YIELD);
      send_task_slot(0, 1'b0, 1'b0, 1, 0);
      send_func(FUNC_TICK);
      send_task_slot(0, 1'b1, 1'b1, 1, 0);
      send_func(FUNC_YIELD);
      drain_results();
   endtask

   task automatic test_preempt_limits();
      repeat (int'(NOPRE_MAX) + 5) send_func(FUNC_PDIS);
      send_func(FUNC_TICK);
      send_func(FUNC_YIELD);
      repeat (int'(NOPRE_MAX) + 6) send_func(FUNC_PEN);
      send_func(FUNC_TICK);
      drain_results();
   endtask

   task automatic test_random_ops();
      repeat (RANDOM_ITEMS) send_op(draw_random_op());
      drain_results();
   endtask

   // The receiver holds off long enough for the block to fill up and stall
   // its input while the sender keeps offering items.
   task automatic test_backpressure();
      gaps_enabled     = 1'b0;
      hold_off_pending = 1'b1;
      repeat (40) send_op(draw_random_op());
      gaps_enabled = 1'b1;
      drain_results();
   endtask

   // Receiver readiness follows one of several patterns, redrawn at random, and stays low during a hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_off_left    = LONG_HOLD_OFF;
         end
         if (hold_off_left != 0) begin
            hold_off_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (rx_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 3));
               rx_left = $urandom_range(8, 80);
            end
            rx_left--;
            case (rx_mode)
               RX_STEADY: rsp_chan.ready <= 1'b1;
               RX_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_chan.ready <= (rx_left % 5 < 3);
            endcase
         end
      end
   end

   task automatic compare_field(input string field, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (decisions_due.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none, actual %p",
                     $time, rsp_chan.payload);
         end else begin
            decision_head = decisions_due.pop_front();
            compare_field("current_task", decision_head.current_task,
                          rsp_chan.payload.current_task);
            compare_field("switched", decision_head.switched, rsp_chan.payload.switched);
            compare_field("rescheduled", decision_head.rescheduled,
                          rsp_chan.payload.rescheduled);
            compare_field("current_count", decision_head.current_count,
                          rsp_chan.payload.current_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      reset_task_table();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_idle_task();
      test_task_table();
      test_preempt_limits();
      test_random_ops();
      test_backpressure();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
